/* rtl/core/vwrm_pkg.sv */
// Package for the vsync wait and refresh meter core.
// Holds register addresses, reset values, field widths and the divider handshake types.
// No dependencies; imported by vwrm_div and vsync_wait_and_refresh_meter_core.
package vwrm_pkg;

  // Field and state widths.
  localparam int unsigned TimeW     = 32;
  localparam int unsigned UsecsW    = 20;
  localparam int unsigned RowsW     = 16;
  localparam int unsigned AttemptsW = 4;
  localparam int unsigned DivW      = 32;
  localparam int unsigned CntW      = 5;
  localparam int unsigned PaddrW    = 4;
  localparam int unsigned PdataW    = 32;
  localparam int unsigned SDataW    = 40;
  localparam int unsigned MDataW    = 40;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] RegUsecsPerRefresh = 2'd0;
  localparam logic [1:0] RegRowsPerRefresh  = 2'd1;
  localparam logic [1:0] RegMonitorEnable   = 2'd2;

  // Reset values.
  localparam logic [UsecsW-1:0] UsecsReset   = 20'd16344;
  localparam logic [RowsW-1:0]  RowsReset    = 16'd646;
  localparam logic [TimeW-1:0]  RowRateReset = 32'd39526;

  // Microseconds per millisecond, used as divisor and as rows scale.
  localparam logic [DivW-1:0] UsPerMs    = 32'd1000;
  localparam logic [9:0]      RowsScale  = 10'd1000;

  // Request to the serial divider: start pulse with operands.
  typedef struct packed {
    logic            start;
    logic [DivW-1:0] num;
    logic [DivW-1:0] den;
  } div_req_t;

  // Divider status: busy while stepping, done for one cycle with the quotient.
  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DivW-1:0] quo;
  } div_rsp_t;

endpackage

/* rtl/core/vwrm_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on vwrm_pkg for widths and the request and status structs.
// A zero divisor yields an all-ones quotient.
module vwrm_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vwrm_pkg::div_req_t req_i,
  output vwrm_pkg::div_rsp_t rsp_o
);
  import vwrm_pkg::*;

  localparam logic [CntW-1:0] LastStep = CntW'(DivW - 1);

  logic [DivW-1:0] rem_q, rem_d;
  logic [DivW-1:0] quo_q, quo_d;
  logic [DivW-1:0] den_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;

  logic [DivW:0]   shifted;
  logic [DivW:0]   diff;
  logic            ge;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem_q, quo_q[DivW-1]};
    diff    = shifted - {1'b0, den_q};
    ge      = shifted >= {1'b0, den_q};
    rem_d   = ge ? diff[DivW-1:0] : shifted[DivW-1:0];
    quo_d   = {quo_q[DivW-2:0], ge};
  end

  // Operand registers and step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        rem_q  <= '0;
        quo_q  <= req_i.num;
        den_q  <= req_i.den;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

  // A start always begins a run of steps.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q)
    else $error("divider did not start");

  // Completion is never reported while steps remain.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while busy");

  // The last step is followed by the done pulse.
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !req_i.start && cnt_q == LastStep) |=> done_q)
    else $error("divider missed done");

endmodule

/* rtl/core/vsync_wait_and_refresh_meter_core.sv */
// Vsync wait and refresh meter: top level with APB registers and stream ports.
// An ordinary item goes from acceptance through evaluation into the output register; a
// measuring item also takes two 32-step divider passes (frame count beside milliseconds,
// then the rate) and a 32-step shift-add multiply before the output register.
// One item is in work at a time; the next is accepted while a result waits for the receiver.
// Reset (rst_ni low, asynchronous) restores all registers and state; no clearing pass.
module vsync_wait_and_refresh_meter_core #(
  parameter int unsigned RETRY_LIMIT = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input item stream.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata: [0] detected, [32:1] time_us, [39:33] zero.
  input  logic [vwrm_pkg::SDataW-1:0] s_axis_tdata,
  // tuser: [0] mode.
  input  logic                        s_axis_tuser,
  // Result item stream.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // tdata: [0] arm_refused, [1] notify, [2] gave_up, [3] measured,
  // [35:4] row_rate, [36] detect_enabled, [39:37] zero.
  output logic [vwrm_pkg::MDataW-1:0] m_axis_tdata,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vwrm_pkg::PaddrW-1:0] paddr,
  input  logic [vwrm_pkg::PdataW-1:0] pwdata,
  output logic [vwrm_pkg::PdataW-1:0] prdata,
  output logic                        pready
);
  import vwrm_pkg::*;

  localparam logic [AttemptsW-1:0] Limit    = AttemptsW'(RETRY_LIMIT);
  localparam logic [CntW-1:0]      MulLast  = CntW'(DivW - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV1,
    ST_MUL,
    ST_DIV2S,
    ST_DIV2,
    ST_FIN
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [UsecsW-1:0] usecs_q;
  logic [RowsW-1:0]  rows_q;
  logic              monitor_q;

  // Block state.
  logic                 pending_q, detect_on_q, have_start_q;
  logic [AttemptsW-1:0] attempts_q;
  logic [TimeW-1:0]     start_time_q, row_rate_q;

  // Captured item and result flags.
  logic             mode_q, det_q;
  logic [TimeW-1:0] time_q;
  logic             refused_q, fire_q, gave_q, meas_q;

  // Measurement datapath.
  logic [DivW-1:0] ms_q, mult_q, mcand_q, prod_q;
  logic [CntW-1:0] cnt_q;

  // Output register.
  logic              m_valid_q;
  logic [MDataW-1:0] m_data_q;

  logic [TimeW-1:0] elapsed;
  logic [TimeW-1:0] rounded;
  logic             miss;
  logic             measure_go;
  logic [25:0]      rows_ms;
  logic             cfg_wr;
  logic             out_free;

  div_req_t div0_req, div1_req;
  div_rsp_t div0_rsp, div1_rsp;

  // Decisions for the captured item.
  always_comb begin
    elapsed    = time_q - start_time_q;
    rounded    = elapsed + TimeW'(usecs_q[UsecsW-1:1]);
    miss       = mode_q && !det_q && (attempts_q <= Limit);
    measure_go = mode_q && det_q && monitor_q && have_start_q && (elapsed >= UsPerMs);
    rows_ms    = rows_q * RowsScale;
  end

  // Shared divider: frame count first, then the row rate.
  always_comb begin
    div0_req.start = ((state_q == ST_EXEC) && measure_go) || (state_q == ST_DIV2S);
    if (state_q == ST_DIV2S) begin
      div0_req.num = prod_q;
      div0_req.den = ms_q;
    end else begin
      div0_req.num = rounded;
      div0_req.den = DivW'(usecs_q);
    end
    div1_req.start = (state_q == ST_EXEC) && measure_go;
    div1_req.num   = elapsed;
    div1_req.den   = UsPerMs;
  end

  vwrm_div u_div_main (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div0_req),
    .rsp_o  (div0_rsp)
  );

  // Milliseconds of the interval, run alongside the frame count.
  vwrm_div u_div_ms (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div1_req),
    .rsp_o  (div1_rsp)
  );

  assign cfg_wr   = psel && penable && pwrite;
  assign out_free = !m_valid_q || m_axis_tready;

  // Sequencer, state, configuration and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      usecs_q      <= UsecsReset;
      rows_q       <= RowsReset;
      monitor_q    <= 1'b0;
      pending_q    <= 1'b0;
      detect_on_q  <= 1'b0;
      have_start_q <= 1'b0;
      attempts_q   <= '0;
      start_time_q <= '0;
      row_rate_q   <= RowRateReset;
      mode_q       <= 1'b0;
      det_q        <= 1'b0;
      time_q       <= '0;
      refused_q    <= 1'b0;
      fire_q       <= 1'b0;
      gave_q       <= 1'b0;
      meas_q       <= 1'b0;
      ms_q         <= '0;
      mult_q       <= '0;
      mcand_q      <= '0;
      prod_q       <= '0;
      cnt_q        <= '0;
      m_valid_q    <= 1'b0;
      m_data_q     <= '0;
    end else begin
      // Register writes.
      if (cfg_wr) begin
        unique case (paddr[3:2])
          RegUsecsPerRefresh: usecs_q   <= pwdata[UsecsW-1:0];
          RegRowsPerRefresh:  rows_q    <= pwdata[RowsW-1:0];
          RegMonitorEnable:   monitor_q <= pwdata[0];
          default: ;
        endcase
      end

      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            mode_q  <= s_axis_tuser;
            det_q   <= s_axis_tdata[0];
            time_q  <= s_axis_tdata[TimeW:1];
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          refused_q <= 1'b0;
          fire_q    <= 1'b0;
          gave_q    <= 1'b0;
          meas_q    <= 1'b0;
          if (!mode_q) begin
            // Arm request.
            if (pending_q) begin
              refused_q <= 1'b1;
            end else begin
              pending_q   <= 1'b1;
              attempts_q  <= AttemptsW'(1);
              detect_on_q <= 1'b1;
            end
          end else if (miss) begin
            attempts_q <= attempts_q + 1'b1;
          end else begin
            // Detection or give-up ends the wait.
            if (det_q && monitor_q) begin
              have_start_q <= 1'b1;
              start_time_q <= time_q;
            end
            fire_q      <= pending_q;
            pending_q   <= 1'b0;
            detect_on_q <= 1'b0;
            attempts_q  <= '0;
            gave_q      <= !det_q;
          end
          state_q <= measure_go ? ST_DIV1 : ST_FIN;
        end
        ST_DIV1: begin
          if (div0_rsp.done && div1_rsp.done) begin
            ms_q    <= div1_rsp.quo;
            mult_q  <= div0_rsp.quo;
            mcand_q <= DivW'(rows_ms);
            prod_q  <= '0;
            cnt_q   <= '0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          // Shift-add multiply, one multiplier bit per cycle, modulo 2^32.
          if (mult_q[0]) begin
            prod_q <= prod_q + mcand_q;
          end
          mcand_q <= {mcand_q[DivW-2:0], 1'b0};
          mult_q  <= {1'b0, mult_q[DivW-1:1]};
          cnt_q   <= cnt_q + 1'b1;
          if (cnt_q == MulLast) begin
            state_q <= ST_DIV2S;
          end
        end
        ST_DIV2S: begin
          state_q <= ST_DIV2;
        end
        ST_DIV2: begin
          if (div0_rsp.done) begin
            row_rate_q <= div0_rsp.quo;
            meas_q     <= 1'b1;
            state_q    <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {3'b000, detect_on_q, row_rate_q, meas_q, gave_q, fire_q, refused_q};
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign pready        = 1'b1;

  // Register read-back.
  always_comb begin
    unique case (paddr[3:2])
      RegUsecsPerRefresh: prdata = PdataW'(usecs_q);
      RegRowsPerRefresh:  prdata = PdataW'(rows_q);
      RegMonitorEnable:   prdata = PdataW'(monitor_q);
      default:            prdata = '0;
    endcase
  end

  // A pending notification and detection enable always move together.
  a_pending_detect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == detect_on_q)
    else $error("pending and detect enable disagree");

  // While waiting on the first divider pass, the divider is working or finishing.
  a_div1_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV1) |-> (div0_rsp.busy || div0_rsp.done))
    else $error("waiting on an idle divider");

  // An accepted item is evaluated in the next cycle.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == ST_EXEC))
    else $error("accepted item not evaluated");

endmodule
